@@ src/ultrasonic_range_controller_macros.svh @@
// assertion helpers, used by the top-level file to check its own logic
`ifndef ULTRASONIC_RANGE_CONTROLLER_MACROS_SVH
`define ULTRASONIC_RANGE_CONTROLLER_MACROS_SVH

// same-cycle implication, checked outside reset
`define URC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define URC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/urc_pkg.sv @@
package urc_pkg;

   // port widths
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 40;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // field widths
   localparam int TS_W    = 16;
   localparam int PHASE_W = 8;
   localparam int SPEED_W = 9;
   localparam int DIST_W  = 14;
   localparam int PROD_W  = TS_W + SPEED_W;

   // width*speed/2000 done as ((width*speed) >> 4) / 125, the /125 by reciprocal
   localparam int                DIV_PRE_SHIFT = 4;
   localparam int                DIV_X_W       = PROD_W - DIV_PRE_SHIFT;
   localparam int                DIV_SHIFT     = 28;
   localparam int                DIV_RECIP_W   = 22;
   localparam logic [21:0]       DIV_RECIP     = 22'd2147484;
   localparam int                DIV_FULL_W    = DIV_X_W + DIV_RECIP_W;
   localparam int                QUOT_W        = DIV_FULL_W - DIV_SHIFT;
   localparam logic [DIST_W-1:0] DIST_MAX      = '1;

   // register reset values
   localparam logic [PHASE_W-1:0] CYCLE_LENGTH_RST = 8'd50;
   localparam logic [PHASE_W-1:0] LISTEN_CLOSE_RST = 8'd19;
   localparam logic [TS_W-1:0]    MIN_WIDTH_RST    = 16'd150;
   localparam logic [SPEED_W-1:0] SOUND_SPEED_RST  = 9'd332;

   // edge count codes
   localparam logic [1:0] EDGES_NONE  = 2'd0;
   localparam logic [1:0] EDGES_START = 2'd1;
   localparam logic [1:0] EDGES_DONE  = 2'd2;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CYCLE_LENGTH = 2'd0,
      CSR_LISTEN_CLOSE = 2'd1,
      CSR_MIN_WIDTH    = 2'd2,
      CSR_SOUND_SPEED  = 2'd3
   } csr_index_type;

   // queue geometry
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;
   localparam int Q_CNT_W = 2;

   // classified item between front and back
   typedef struct packed {
      logic            is_edge;
      logic            ch_ok;
      logic            ch;
      logic [TS_W-1:0] ts;
   } item_type;

   // queue status seen by the front
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // per-item info carried down the back pipeline
   typedef struct packed {
      logic            ch_ok;
      logic            ch;
      logic            upd;
      logic [TS_W-1:0] width;
      logic [1:0]      tmask;
      logic [1:0]      lmask;
   } stage_type;

endpackage

@@ src/urc_front.sv @@
module urc_front #(
   parameter int CHANNELS = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [urc_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic                                req_tuser,
   input  urc_pkg::q_stat_type                 q_stat,
   output logic                                push,
   output urc_pkg::item_type                   push_item
);
   import urc_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take;

   // hold one item; free when empty or when it moves into the queue
   assign push       = valid_ff && !q_stat.full;
   assign req_tready = !valid_ff || !q_stat.full;
   assign take       = req_tvalid && req_tready;
   assign push_item  = item_ff;

   // classify the incoming item
   always_comb begin
      item_in.is_edge = req_tuser;
      item_in.ch      = req_tdata[0];
      item_in.ch_ok   = (int'(req_tdata[0]) < CHANNELS);
      item_in.ts      = req_tdata[TS_W:1];
      valid_in        = take || (valid_ff && !push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         item_ff <= item_in;
      end
   end

endmodule

@@ src/urc_queue.sv @@
module urc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  urc_pkg::item_type   push_item,
   input  logic                pop,
   output urc_pkg::item_type   pop_item,
   output urc_pkg::q_stat_type q_stat
);
   import urc_pkg::*;

   item_type             mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   cnt_ff, cnt_in;

   assign q_stat.full  = (cnt_ff == Q_CNT_W'(Q_DEPTH));
   assign q_stat.empty = (cnt_ff == '0);
   assign pop_item     = mem_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ src/urc_back.sv @@
module urc_back #(
   parameter int CHANNELS = 2
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  urc_pkg::item_type                 q_item,
   output logic                              pop,
   input  logic                              csr_we,
   input  logic [urc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [urc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [urc_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tuser
);
   import urc_pkg::*;

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // configuration
   logic [PHASE_W-1:0] cycle_len_ff;
   logic [PHASE_W-1:0] close_ff;
   logic [TS_W-1:0]    min_width_ff;
   logic [SPEED_W-1:0] speed_ff;

   // scheduler and channel state
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [CHANNELS-1:0] trig_ff, trig_in;
   logic [CHANNELS-1:0] listen_ff, listen_in;
   logic [1:0]          cnt_ff   [CHANNELS];
   logic [1:0]          cnt_in   [CHANNELS];
   logic [TS_W-1:0]     start_ff [CHANNELS];
   logic [TS_W-1:0]     start_in [CHANNELS];
   logic [TS_W-1:0]     width_ff [CHANNELS];
   logic [DIST_W-1:0]   dist_ff  [CHANNELS];

   // pipeline
   logic                adv;
   logic                a_valid_ff, b_valid_ff, rsp_valid_ff;
   stage_type           a_ff, a_in, b_ff;
   logic [PROD_W-1:0]   a_prod_ff, a_prod_in;
   logic [QUOT_W-1:0]   b_quot_ff, b_quot_in;
   logic [DIV_FULL_W-1:0] div_full;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                rsp_upd_ff;

   logic [IDX_W-1:0]    q_idx, b_idx;
   logic [TS_W-1:0]     edge_width;
   logic [PHASE_W:0]    phase_sum;
   logic [CHANNELS+1:0] trig_ext, listen_ext;
   logic [DIST_W-1:0]   c_dist;
   logic [TS_W-1:0]     out_width;
   logic [DIST_W-1:0]   out_dist;
   logic                ch_listen;
   logic [1:0]          ch_cnt;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign pop        = adv && q_valid;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_upd_ff;

   assign q_idx = IDX_W'(q_item.ch);
   assign b_idx = IDX_W'(b_ff.ch);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cycle_len_ff <= CYCLE_LENGTH_RST;
         close_ff     <= LISTEN_CLOSE_RST;
         min_width_ff <= MIN_WIDTH_RST;
         speed_ff     <= SOUND_SPEED_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_CYCLE_LENGTH: cycle_len_ff <= csr_wdata[PHASE_W-1:0];
            CSR_LISTEN_CLOSE: close_ff     <= csr_wdata[PHASE_W-1:0];
            CSR_MIN_WIDTH:    min_width_ff <= csr_wdata[TS_W-1:0];
            CSR_SOUND_SPEED:  speed_ff     <= csr_wdata[SPEED_W-1:0];
            default:          cycle_len_ff <= cycle_len_ff;
         endcase
      end
   end

   // stage a: state update for the popped item, width and product
   always_comb begin
      ch_listen  = q_item.ch_ok && listen_ff[q_idx];
      ch_cnt     = cnt_ff[q_idx];
      edge_width = q_item.ts - start_ff[q_idx];
      phase_sum  = {1'b0, phase_ff} + 1'b1;
      phase_in   = phase_ff;
      trig_in    = trig_ff;
      listen_in  = listen_ff;
      for (int c = 0; c < CHANNELS; c++) begin
         cnt_in[c]   = cnt_ff[c];
         start_in[c] = start_ff[c];
      end
      if (pop && !q_item.is_edge) begin
         // scheduler tick: phase-0, phase-1 then close actions, close wins
         for (int c = 0; c < CHANNELS; c++) begin
            if (phase_ff == '0) begin
               trig_in[c] = 1'b1;
            end
            if (phase_ff == PHASE_W'(1)) begin
               trig_in[c]   = 1'b0;
               cnt_in[c]    = EDGES_NONE;
               listen_in[c] = 1'b1;
            end
            if (phase_ff == close_ff) begin
               listen_in[c] = 1'b0;
               trig_in[c]   = 1'b0;
            end
         end
         phase_in = (phase_sum >= {1'b0, cycle_len_ff}) ? '0 : phase_sum[PHASE_W-1:0];
      end else if (pop && ch_listen) begin
         // echo edge on a listening channel
         for (int c = 0; c < CHANNELS; c++) begin
            if (c == int'(q_item.ch)) begin
               if (cnt_ff[c] == EDGES_NONE) begin
                  start_in[c] = q_item.ts;
                  cnt_in[c]   = EDGES_START;
               end else if (cnt_ff[c] == EDGES_START) begin
                  cnt_in[c] = EDGES_DONE;
               end
            end
         end
      end
      trig_ext   = {2'b00, trig_in};
      listen_ext = {2'b00, listen_in};
      a_in.ch_ok = q_item.ch_ok;
      a_in.ch    = q_item.ch;
      a_in.upd   = q_item.is_edge && ch_listen && (ch_cnt == EDGES_START) &&
                   (edge_width > min_width_ff);
      a_in.width = edge_width;
      a_in.tmask = trig_ext[1:0];
      a_in.lmask = listen_ext[1:0];
      a_prod_in  = PROD_W'(edge_width) * PROD_W'(speed_ff);
   end

   // stage b: divide by 2000 as a reciprocal multiply
   always_comb begin
      div_full  = DIV_FULL_W'(a_prod_ff[PROD_W-1:DIV_PRE_SHIFT]) * DIV_FULL_W'(DIV_RECIP);
      b_quot_in = div_full[DIV_FULL_W-1:DIV_SHIFT];
   end

   // stage c: saturate, store measurement, build the result
   always_comb begin
      c_dist    = (b_quot_ff > QUOT_W'(DIST_MAX)) ? DIST_MAX : b_quot_ff[DIST_W-1:0];
      out_width = '0;
      out_dist  = '0;
      if (b_ff.upd) begin
         out_width = b_ff.width;
         out_dist  = c_dist;
      end else if (b_ff.ch_ok) begin
         out_width = width_ff[b_idx];
         out_dist  = dist_ff[b_idx];
      end
      rsp_data_in = RSP_TDATA_W'({out_dist, out_width, b_ff.lmask, b_ff.tmask});
   end

   // state and pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         trig_ff      <= '0;
         listen_ff    <= CHANNELS'(1);
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            cnt_ff[c]   <= EDGES_NONE;
            width_ff[c] <= '0;
            dist_ff[c]  <= '0;
         end
      end else begin
         phase_ff  <= phase_in;
         trig_ff   <= trig_in;
         listen_ff <= listen_in;
         for (int c = 0; c < CHANNELS; c++) begin
            cnt_ff[c] <= cnt_in[c];
         end
         if (adv) begin
            a_valid_ff   <= pop;
            b_valid_ff   <= a_valid_ff;
            rsp_valid_ff <= b_valid_ff;
            if (b_valid_ff && b_ff.upd) begin
               width_ff[b_idx] <= b_ff.width;
               dist_ff[b_idx]  <= c_dist;
            end
         end
      end
      for (int c = 0; c < CHANNELS; c++) begin
         start_ff[c] <= start_in[c];
      end
      if (adv) begin
         a_ff        <= a_in;
         a_prod_ff   <= a_prod_in;
         b_ff        <= a_ff;
         b_quot_ff   <= b_quot_in;
         rsp_data_ff <= rsp_data_in;
         rsp_upd_ff  <= b_ff.upd;
      end
   end

endmodule

@@ src/ultrasonic_range_controller.sv @@
// Multi-channel ultrasonic ranger.
// Request channel (req_): one item per scheduler tick (req_tuser = 0) or per echo
// edge (req_tuser = 1) on the channel in req_tdata, with its microsecond timestamp.
// Response channel (rsp_): exactly one item per request, in order, carrying the
// trigger and listen masks after that item and the stored width and distance of
// the item's channel; rsp_tuser marks an item that stored a new measurement.
// Register port (csr_): index 0 cycle length, 1 listen close phase, 2 minimum
// width in us, 3 speed of sound in m/s; the user must see that they are written
// only while the block is idle; the block does not enforce it. A request passes
// the input register, queue, state-update stage, divide stage, response register.
// Throughput: one item per cycle unless the response stalls; the phase and channel
// state update on a pop, and width*speed/2000 is split over two multiplier stages.
// Reset: phase 0, channel 0 listening, triggers off, stored measurements zero,
// registers at 50 / 19 / 150 / 332.
// A stalled response freezes the back pipeline; a two-entry queue and the input
// register keep taking requests until they fill, then req_tready drops.
module ultrasonic_range_controller #(
   parameter int CHANNELS = 2
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // channel [0], timestamp_us [16:1], zero [23:17]
   input  logic [urc_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // operation [0]
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // trigger_mask [1:0], listen_mask [3:2], width_us [19:4], distance_mm [33:20],
   // zero [39:34]
   output logic [urc_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // updated [0]
   output logic                              rsp_tuser,
   input  logic                              csr_we,
   input  logic [urc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [urc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import urc_pkg::*;

   `include "ultrasonic_range_controller_macros.svh"

   q_stat_type q_stat;
   item_type   push_item, pop_item;
   logic       push, pop;

   // accept and classify
   urc_front #(.CHANNELS(CHANNELS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_stat     (q_stat),
      .push       (push),
      .push_item  (push_item)
   );

   // decoupling queue
   urc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .q_stat    (q_stat)
   );

   // state update, distance and response
   urc_back #(.CHANNELS(CHANNELS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (!q_stat.empty),
      .q_item     (pop_item),
      .pop        (pop),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // queue never overflows or underflows
   `URC_ASSERT_NOW(a_no_push_full, clock, reset, q_stat.full, !push, "push into full queue")
   `URC_ASSERT_NOW(a_no_pop_empty, clock, reset, pop, !q_stat.empty, "pop from empty queue")
   // an item pushed into an empty queue is visible next cycle
   `URC_ASSERT_NEXT(a_push_seen, clock, reset, push && q_stat.empty, !q_stat.empty,
                    "pushed item lost")

endmodule
